/* src/dofa_pkg.sv */
// Shared types, constants and the sine table of the delayed output feedback assist block.
package dofa_pkg;

   localparam int DELAY_DEPTH_DEF = 2048;

   localparam int ANGLE_W     = 16;
   localparam int TORQUE_W    = 16;
   localparam int GAIN_W      = 16;
   localparam int DELAY_W     = 11;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [GAIN_W-1:0]      GAIN_RESET  = 16'd3840;
   localparam logic [DELAY_W-1:0]     DELAY_RESET = 11'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_GAIN    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_DELAY   = 2'd1;

   // alpha = 0.05 in Q0.16
   localparam logic signed [13:0] ALPHA_Q16   = 14'sd3277;
   localparam logic [16:0]        HALF_PI_Q14 = 17'd25736;
   localparam logic [16:0]        PI_Q14      = 17'd51472;
   localparam logic [7:0]         POS_SCALE   = 8'd163;
   localparam logic [14:0]        SINE_ONE    = 15'd16384;
   localparam logic [5:0]         TAB_LAST    = 6'd32;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILT,
      ST_FOLD,
      ST_INTERP,
      ST_WRITE,
      ST_READ,
      ST_MUL,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic load;
      logic filt;
      logic fold;
      logic interp;
      logic write;
      logic read;
      logic mul;
      logic out;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

   // sin(k*pi/64) in Q1.14, k = 0..32
   function automatic logic [14:0] sine_tab(input logic [5:0] idx);
      logic [14:0] v;
      case (idx)
         6'd0:  v = 15'd0;
         6'd1:  v = 15'd804;
         6'd2:  v = 15'd1606;
         6'd3:  v = 15'd2404;
         6'd4:  v = 15'd3196;
         6'd5:  v = 15'd3981;
         6'd6:  v = 15'd4756;
         6'd7:  v = 15'd5520;
         6'd8:  v = 15'd6270;
         6'd9:  v = 15'd7005;
         6'd10: v = 15'd7723;
         6'd11: v = 15'd8423;
         6'd12: v = 15'd9102;
         6'd13: v = 15'd9760;
         6'd14: v = 15'd10394;
         6'd15: v = 15'd11003;
         6'd16: v = 15'd11585;
         6'd17: v = 15'd12140;
         6'd18: v = 15'd12665;
         6'd19: v = 15'd13160;
         6'd20: v = 15'd13623;
         6'd21: v = 15'd14053;
         6'd22: v = 15'd14449;
         6'd23: v = 15'd14811;
         6'd24: v = 15'd15137;
         6'd25: v = 15'd15426;
         6'd26: v = 15'd15679;
         6'd27: v = 15'd15893;
         6'd28: v = 15'd16069;
         6'd29: v = 15'd16207;
         6'd30: v = 15'd16305;
         6'd31: v = 15'd16364;
         default: v = SINE_ONE;
      endcase
      return v;
   endfunction

endpackage

/* src/dofa_sine.sv */
// Two-step sine lane: fold and scale the angle, then interpolate the table.
module dofa_sine (
   input  logic                                 clock,
   input  logic signed [dofa_pkg::ANGLE_W-1:0]  angle,
   input  logic                                 fold_en,
   input  logic                                 interp_en,
   output logic signed [dofa_pkg::ANGLE_W-1:0]  sine
);

   logic               neg_ff;
   logic [22:0]        pos_ff;
   logic [22:0]        pos_in;
   logic signed [15:0] sine_ff;
   logic signed [15:0] sine_in;

   logic signed [16:0] ang_x;
   logic [16:0]        mag;
   logic [16:0]        folded;

   logic [5:0]         idx;
   logic [16:0]        frac;
   logic [14:0]        t0;
   logic [14:0]        t1;
   logic [9:0]         dt;
   logic [27:0]        step;
   logic [10:0]        corr;
   logic [14:0]        v;

   always_comb begin
      ang_x  = 17'(angle);
      mag    = (ang_x < 0) ? 17'(-ang_x) : 17'(ang_x);
      // beyond pi/2 use sin(pi - a)
      folded = (mag > dofa_pkg::HALF_PI_Q14) ? (dofa_pkg::PI_Q14 - mag) : mag;
      pos_in = 23'(folded[14:0]) * 23'(dofa_pkg::POS_SCALE);
   end

   always_comb begin
      idx  = pos_ff[22:17];
      frac = pos_ff[16:0];
      t0   = dofa_pkg::sine_tab(idx);
      t1   = dofa_pkg::sine_tab(idx + 6'd1);
      dt   = 10'(t1 - t0);
      step = 28'(dt) * 28'(frac);
      corr = 11'((step + 28'd65536) >> 17);
      v    = (idx >= dofa_pkg::TAB_LAST) ? dofa_pkg::SINE_ONE : (t0 + 15'(corr));
      sine_in = neg_ff ? -$signed(16'(v)) : $signed(16'(v));
   end

   always_ff @(posedge clock) begin
      if (fold_en) begin
         neg_ff <= angle[15];
         pos_ff <= pos_in;
      end
      if (interp_en) begin
         sine_ff <= sine_in;
      end
   end

   assign sine = sine_ff;

endmodule

/* src/dofa_ctrl.sv */
// Sequencer that steps one control tick through the datapath.
module dofa_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  dofa_pkg::status_type status,
   output dofa_pkg::cmd_type    cmd
);

   dofa_pkg::state_type state_ff;
   dofa_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dofa_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         dofa_pkg::ST_IDLE: begin
            // hold off transfers while reset is applied
            req_tready = !reset;
            if (req_tvalid && !reset) begin
               cmd.load = 1'b1;
               state_in = dofa_pkg::ST_FILT;
            end
         end
         dofa_pkg::ST_FILT: begin
            cmd.filt = 1'b1;
            state_in = dofa_pkg::ST_FOLD;
         end
         dofa_pkg::ST_FOLD: begin
            cmd.fold = 1'b1;
            state_in = dofa_pkg::ST_INTERP;
         end
         dofa_pkg::ST_INTERP: begin
            cmd.interp = 1'b1;
            state_in   = dofa_pkg::ST_WRITE;
         end
         dofa_pkg::ST_WRITE: begin
            cmd.write = 1'b1;
            state_in  = dofa_pkg::ST_READ;
         end
         dofa_pkg::ST_READ: begin
            cmd.read = 1'b1;
            state_in = dofa_pkg::ST_MUL;
         end
         dofa_pkg::ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = dofa_pkg::ST_OUT;
         end
         dofa_pkg::ST_OUT: begin
            // hold until the output register can take the result
            if (status.out_free) begin
               cmd.out  = 1'b1;
               state_in = dofa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dofa_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

/* src/dofa_dp.sv */
// Datapath: filters, sine lanes, delay line memory, gain multiply and output register.
module dofa_dp #(
   parameter int DELAY_DEPTH = dofa_pkg::DELAY_DEPTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  dofa_pkg::cmd_type                    cmd,
   output dofa_pkg::status_type                 status,
   input  logic [31:0]                          req_tdata,
   input  logic                                 csr_valid,
   input  logic [dofa_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [dofa_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                 rsp_tready,
   output logic                                 rsp_tvalid,
   output logic [31:0]                          rsp_tdata
);

   localparam int AW = $clog2(DELAY_DEPTH);
   localparam int FW = $clog2(DELAY_DEPTH + 1);
   localparam int CW = (AW > dofa_pkg::DELAY_W) ? AW : dofa_pkg::DELAY_W;
   localparam logic [CW-1:0] DELAY_MAX  = CW'(DELAY_DEPTH - 1);
   localparam logic [AW-1:0] LAST_ADDR  = AW'(DELAY_DEPTH - 1);
   localparam logic [AW:0]   DEPTH_X    = (AW + 1)'(DELAY_DEPTH);
   localparam logic [FW-1:0] FILL_FULL  = FW'(DELAY_DEPTH);

   function automatic logic signed [15:0] lowpass(input logic signed [15:0] cur,
                                                  input logic signed [15:0] prev);
      logic signed [16:0] diff;
      logic signed [30:0] scaled;
      logic signed [30:0] rnd;
      diff   = 17'(cur) - 17'(prev);
      // prev*(1-alpha) + cur*alpha == prev*2^16 + (cur-prev)*alpha
      scaled = 31'(diff) * 31'(dofa_pkg::ALPHA_Q16);
      rnd    = (scaled + 31'sd32768) >>> 16;
      return 16'(17'(prev) + 17'(rnd));
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [17:0] x);
      if (x > 18'sd32767) begin
         return 16'sh7FFF;
      end else if (x < -18'sd32768) begin
         return 16'sh8000;
      end
      return 16'(x);
   endfunction

   logic [dofa_pkg::GAIN_W-1:0]  gain_ff;
   logic [dofa_pkg::DELAY_W-1:0] delay_ff;

   logic signed [15:0] raw_l_ff, raw_r_ff;
   logic signed [15:0] filt_l_ff, filt_r_ff;
   logic signed [15:0] prev_l, prev_r;
   logic               both_zero;

   logic signed [15:0] sin_l, sin_r;
   logic signed [16:0] y_diff;
   logic signed [15:0] y_in;

   logic signed [15:0] ram [DELAY_DEPTH];
   logic [AW-1:0]      wp_ff;
   logic [AW-1:0]      wp_in;
   logic [FW-1:0]      fill_ff;
   logic [FW-1:0]      fill_in;
   logic [CW-1:0]      delay_cw;
   logic [AW-1:0]      d_sat;
   logic [AW-1:0]      rd_addr_in;
   logic [AW-1:0]      rd_addr_ff;
   logic               hit_ff;
   logic signed [15:0] rd_data_ff;

   logic signed [15:0] yd;
   logic signed [33:0] prod_full;
   logic signed [31:0] prod_ff;
   logic signed [32:0] r_full;
   logic signed [17:0] r_x;
   logic signed [17:0] nr_x;

   logic               rsp_valid_ff;
   logic [31:0]        rsp_data_ff;
   logic [31:0]        rsp_data_in;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff  <= dofa_pkg::GAIN_RESET;
         delay_ff <= dofa_pkg::DELAY_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            dofa_pkg::REG_GAIN:  gain_ff  <= csr_wdata;
            dofa_pkg::REG_DELAY: delay_ff <= csr_wdata[dofa_pkg::DELAY_W-1:0];
            default: ;
         endcase
      end
   end

   // low-pass filters; seed with the raw angles while both filter states are zero
   always_comb begin
      both_zero = (filt_l_ff == 16'sd0) && (filt_r_ff == 16'sd0);
      prev_l    = both_zero ? raw_l_ff : filt_l_ff;
      prev_r    = both_zero ? raw_r_ff : filt_r_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         raw_l_ff <= req_tdata[15:0];
         raw_r_ff <= req_tdata[31:16];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filt_l_ff <= '0;
         filt_r_ff <= '0;
      end else if (cmd.filt) begin
         filt_l_ff <= lowpass(raw_l_ff, prev_l);
         filt_r_ff <= lowpass(raw_r_ff, prev_r);
      end
   end

   dofa_sine u_sine_l (
      .clock     (clock),
      .angle     (filt_l_ff),
      .fold_en   (cmd.fold),
      .interp_en (cmd.interp),
      .sine      (sin_l)
   );

   dofa_sine u_sine_r (
      .clock     (clock),
      .angle     (filt_r_ff),
      .fold_en   (cmd.fold),
      .interp_en (cmd.interp),
      .sine      (sin_r)
   );

   always_comb begin
      y_diff = 17'(sin_r) - 17'(sin_l);
      y_in   = sat16(18'(y_diff));
   end

   // delay line addressing; fill count stands in for clearing the memory
   always_comb begin
      delay_cw = CW'(delay_ff);
      d_sat    = (delay_cw > DELAY_MAX) ? LAST_ADDR : AW'(delay_cw);
      if (wp_ff >= d_sat) begin
         rd_addr_in = wp_ff - d_sat;
      end else begin
         rd_addr_in = AW'((AW + 1)'(wp_ff) + DEPTH_X - (AW + 1)'(d_sat));
      end
      wp_in   = (wp_ff == LAST_ADDR) ? '0 : wp_ff + AW'(1);
      fill_in = (fill_ff == FILL_FULL) ? fill_ff : fill_ff + FW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         fill_ff <= '0;
      end else if (cmd.write) begin
         wp_ff   <= wp_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write) begin
         rd_addr_ff <= rd_addr_in;
         hit_ff     <= (FW'(d_sat) < fill_in);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write) begin
         ram[wp_ff] <= y_in;
      end
      if (cmd.read) begin
         rd_data_ff <= ram[rd_addr_ff];
      end
   end

   // gain multiply; an entry never written reads as zero
   always_comb begin
      yd        = hit_ff ? rd_data_ff : 16'sd0;
      prod_full = 34'(yd) * $signed(34'(gain_ff));
   end

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prod_ff <= prod_full[31:0];
      end
   end

   always_comb begin
      r_full      = (33'(prod_ff) + 33'sd32768) >>> 16;
      r_x         = 18'(r_full);
      nr_x        = -r_x;
      rsp_data_in = {sat16(nr_x), sat16(r_x)};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = rsp_data_ff;

endmodule

/* src/delayed_output_feedback_assist_core.sv */
// Top level of the delayed output feedback assist block.
//
// One control tick enters on the req_ stream: left and right hip angles in
// signed Q2.14. Each tick produces exactly one transfer on the rsp_ stream
// carrying the left torque and the right torque, its negation, signed Q10.6,
// saturated. The csr_ channel writes the gain (index 0, unsigned Q8.8) and
// the delay in ticks (index 1); csr_ready is high outside reset and writes
// belong in idle periods.
//
// A tick walks a sequencer of eight steps: accept, filter, fold, interpolate,
// delay line write, delay line read, gain multiply, output. rsp_tvalid rises
// from the register loaded in the output step; a new tick is taken only once
// the sequencer, with its single-port use of the delay line, returns to accept.
// The output register frees the input side: the next tick is accepted while
// a result waits; if the receiver still holds rsp_tready low when the next
// result is ready, the sequencer waits in its output step.
//
// Reset clears the filter states, the delay line pointer and its fill count
// (entries not yet written read as zero, so no clearing pass is needed) and
// restores the register defaults. req_tready and csr_ready stay low during
// reset and rise in the first cycle after it.
module delayed_output_feedback_assist_core #(
   parameter int DELAY_DEPTH = dofa_pkg::DELAY_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // req_tdata: left_angle [15:0], right_angle [31:16]
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [31:0]                      req_tdata,
   // rsp_tdata: torque_left [15:0], torque_right [31:16]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [31:0]                      rsp_tdata,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [dofa_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [dofa_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   dofa_pkg::cmd_type    cmd;
   dofa_pkg::status_type status;

   assign csr_ready = !reset;

   dofa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   dofa_dp #(
      .DELAY_DEPTH (DELAY_DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

   // not ready again right after a transfer in
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input accepted twice within one tick");

   // never overwrite a result the receiver has not taken
   assert property (@(posedge clock) disable iff (reset)
      cmd.out |-> (!rsp_tvalid || rsp_tready))
      else $error("output register overwritten");

   // right torque is the negated left torque, up to the saturation corner
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((16'(rsp_tdata[31:16] + rsp_tdata[15:0]) == 16'h0000)
                   || (16'(rsp_tdata[31:16] + rsp_tdata[15:0]) == 16'hFFFF)))
      else $error("torque pair not symmetric");

endmodule

/* bench/tb.sv */
// Self-checking bench for the assist core: drives angle ticks, predicts and checks torque transfers.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LINE_DEPTH     = dofa_pkg::DELAY_DEPTH_DEF;
   localparam int ANGLE_MAX      = dofa_pkg::HALF_PI_Q14;
   localparam int ANGLE_FOLD     = dofa_pkg::PI_Q14;
   localparam int ALPHA          = dofa_pkg::ALPHA_Q16;
   localparam int KEEP           = 65536 - ALPHA;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int PHASE_TICKS    = 128;
   localparam int NUM_PHASES     = 8;

   // indexes past the two real registers; writes there must be dropped
   localparam logic [dofa_pkg::CSR_INDEX_W-1:0] REG_SPARE_A = 2'd2;
   localparam logic [dofa_pkg::CSR_INDEX_W-1:0] REG_SPARE_B = 2'd3;

   typedef struct packed {
      logic signed [dofa_pkg::TORQUE_W-1:0] right;
      logic signed [dofa_pkg::TORQUE_W-1:0] left;
   } torque_pair_type;

   class torque_board;
      int gain;
      int delay_ticks;
      int filt_l;
      int filt_r;
      int y_line [LINE_DEPTH];
      int wr_ptr;
      int quarter_sine [33];
      torque_pair_type torque_due [$];
      int mismatches;
      int checked;
      int reloads;

      function new();
         gain        = int'(dofa_pkg::GAIN_RESET);
         delay_ticks = int'(dofa_pkg::DELAY_RESET);
         filt_l      = 0;
         filt_r      = 0;
         wr_ptr      = 0;
         mismatches  = 0;
         checked     = 0;
         reloads     = 0;
         foreach (y_line[i]) y_line[i] = 0;
         quarter_sine = '{0, 804, 1606, 2404, 3196, 3981, 4756, 5520,
                          6270, 7005, 7723, 8423, 9102, 9760, 10394, 11003,
                          11585, 12140, 12665, 13160, 13623, 14053, 14449, 14811,
                          15137, 15426, 15679, 15893, 16069, 16207, 16305, 16364,
                          16384};
      endfunction

      function int sat16(longint v);
         if (v > 32767) return 32767;
         if (v < -32768) return -32768;
         return int'(v);
      endfunction

      function int lowpass(int cur, int prev);
         longint acc;
         acc = longint'(prev) * KEEP + longint'(cur) * ALPHA + 32768;
         return int'(acc >>> 16);
      endfunction

      // fold to the first quadrant, then interpolate the table
      function int sine_q14(int ang);
         int a;
         int unsigned pos;
         int unsigned idx;
         int unsigned frac;
         longint step;
         int v;
         a = (ang < 0) ? -ang : ang;
         if (a > ANGLE_MAX) a = ANGLE_FOLD - a;
         pos  = a * int'(dofa_pkg::POS_SCALE);
         idx  = pos >> 17;
         frac = pos & 32'h1FFFF;
         if (idx >= 32) begin
            v = quarter_sine[32];
         end else begin
            step = longint'(quarter_sine[idx + 1] - quarter_sine[idx]) * longint'(frac) + 65536;
            v = quarter_sine[idx] + int'(step >>> 17);
         end
         return (ang < 0) ? -v : v;
      endfunction

      function void set_reg(logic [dofa_pkg::CSR_INDEX_W-1:0] idx,
                            logic [dofa_pkg::CSR_DATA_W-1:0] val);
         case (idx)
            dofa_pkg::REG_GAIN:  gain = int'(val);
            dofa_pkg::REG_DELAY: delay_ticks = int'(val[dofa_pkg::DELAY_W-1:0]);
            default: ;
         endcase
      endfunction

      function void note_tick(logic signed [dofa_pkg::ANGLE_W-1:0] raw_l,
                              logic signed [dofa_pkg::ANGLE_W-1:0] raw_r);
         int cur_l;
         int cur_r;
         int prev_l;
         int prev_r;
         int y;
         int d;
         int rd;
         longint r;
         torque_pair_type t;
         cur_l  = int'(raw_l);
         cur_r  = int'(raw_r);
         prev_l = filt_l;
         prev_r = filt_r;
         // both filters at zero: load the raw angles
         if (prev_l == 0 && prev_r == 0) begin
            prev_l = cur_l;
            prev_r = cur_r;
            reloads++;
         end
         filt_l = lowpass(cur_l, prev_l);
         filt_r = lowpass(cur_r, prev_r);
         y = sat16(longint'(sine_q14(filt_r)) - sine_q14(filt_l));
         y_line[wr_ptr] = y;
         d  = (delay_ticks > LINE_DEPTH - 1) ? LINE_DEPTH - 1 : delay_ticks;
         rd = (wr_ptr >= d) ? wr_ptr - d : wr_ptr + LINE_DEPTH - d;
         wr_ptr = (wr_ptr + 1 >= LINE_DEPTH) ? 0 : wr_ptr + 1;
         r = (longint'(y_line[rd]) * longint'(gain) + 32768) >>> 16;
         t.left  = 16'(sat16(r));
         t.right = 16'(sat16(-r));
         torque_due.push_back(t);
      endfunction

      function void check_torque(logic [2*dofa_pkg::TORQUE_W-1:0] data);
         torque_pair_type got;
         torque_pair_type want;
         got = data;
         if (torque_due.size() == 0) begin
            if (mismatches < 10)
               $display("torque transfer with nothing expected: left %0d right %0d",
                        got.left, got.right);
            mismatches++;
         end else begin
            want = torque_due.pop_front();
            if (got.left !== want.left || got.right !== want.right) begin
               if (mismatches < 10)
                  $display("torque %0d: expected left %0d right %0d, got left %0d right %0d",
                           checked, want.left, want.right, got.left, got.right);
               mismatches++;
            end
         end
         checked++;
      endfunction

      function int pending();
         return torque_due.size();
      endfunction
   endclass

   logic                             clock = 1'b0;
   logic                             reset;
   logic                             req_tvalid;
   logic                             req_tready;
   logic [31:0]                      req_tdata;
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   logic [31:0]                      rsp_tdata;
   logic                             csr_valid;
   logic                             csr_ready;
   logic [dofa_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [dofa_pkg::CSR_DATA_W-1:0]  csr_wdata;

   torque_board board = new();
   bit calm = 1'b0;
   int ticks_sent = 0;

   delayed_output_feedback_assist_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int clamp_angle(int v);
      if (v > ANGLE_MAX) return ANGLE_MAX;
      if (v < -ANGLE_MAX) return -ANGLE_MAX;
      return v;
   endfunction

   function automatic int tri_wave(int step, int period, int amp);
      int u;
      u = step % period;
      if (u > period / 2) u = period - u;
      return -amp + (4 * amp * u) / period;
   endfunction

   function automatic int extreme_angle(int sel);
      case (sel)
         0: return ANGLE_MAX;
         1: return -ANGLE_MAX;
         2: return 0;
         3: return 1;
         4: return -1;
         5: return 32767;
         default: return -32768;
      endcase
   endfunction

   // raw angle that brings a filter holding p to zero, or as close as the range allows
   function automatic int zero_pull(int p);
      longint base;
      longint c;
      base = longint'(p) * KEEP + 32768;
      c = -(base / ALPHA);
      while (base + c * ALPHA < 0) c++;
      while (base + c * ALPHA > 65535) c--;
      if (c > ANGLE_MAX) c = ANGLE_MAX;
      if (c < -ANGLE_MAX) c = -ANGLE_MAX;
      return int'(c);
   endfunction

   task automatic send_tick(input int left_ang, input int right_ang);
      logic signed [dofa_pkg::ANGLE_W-1:0] l16;
      logic signed [dofa_pkg::ANGLE_W-1:0] r16;
      l16 = 16'(left_ang);
      r16 = 16'(right_ang);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {r16, l16};
      do @(posedge clock); while (!req_tready);
      board.note_tick(l16, r16);
      ticks_sent++;
   endtask

   // leaves csr_valid high; the caller drops it after the last write of a group
   task automatic write_csr(input logic [dofa_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [dofa_pkg::CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      board.set_reg(idx, val);
   endtask

   // result side: random stall bursts, none once calm is set
   initial begin
      int hold;
      hold = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) board.check_torque(rsp_tdata);
         if (hold > 0) hold--;
         else if (!calm && $urandom_range(0, 9) == 0) hold = $urandom_range(1, 14);
         rsp_tready <= (hold == 0) && !reset;
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      logic [dofa_pkg::CSR_DATA_W-1:0] phase_gain [NUM_PHASES];
      logic [dofa_pkg::CSR_DATA_W-1:0] phase_delay [NUM_PHASES];
      int ph;
      int k;
      int kind;
      int len;
      int amp;
      int period;
      int offs;
      int start;
      int guard;

      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= '0;
      csr_wdata  <= '0;
      reset      <= 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      phase_gain  = '{16'hFFFF, 16'd0, 16'd256, 16'd3840, 16'd0, 16'hFFFF, 16'd0, 16'd3840};
      phase_delay = '{16'hFFFF, 16'd0, 16'd1, 16'hF80A, 16'd0, 16'd700, 16'd0, 16'd3};
      phase_gain[4]  = 16'($urandom);
      phase_delay[4] = 16'($urandom_range(0, 300));
      phase_gain[6]  = 16'($urandom);
      phase_delay[6] = 16'($urandom);

      // directed ticks at the reset gain and delay
      write_csr(REG_SPARE_A, 16'hFFFF);
      write_csr(REG_SPARE_B, 16'h5A5A);
      csr_valid <= 1'b0;
      send_tick(0, 0);
      send_tick(0, 0);
      send_tick(1, 1);
      send_tick(-10, -10);        // both filters land on zero
      send_tick(32767, -32768);   // reload past pi/2 on both sides
      send_tick(0, 0);
      send_tick(ANGLE_MAX, -ANGLE_MAX);
      send_tick(-ANGLE_MAX, ANGLE_MAX);
      send_tick(16'sh5555, 16'shAAAA);
      send_tick(-1, 1);
      send_tick(-32768, 32767);
      send_tick(12000, -3000);
      send_tick(ANGLE_MAX, ANGLE_MAX);
      req_tvalid <= 1'b0;

      for (ph = 0; ph < NUM_PHASES; ph++) begin
         while (board.pending() != 0) @(posedge clock);
         repeat (12) @(posedge clock);
         write_csr(dofa_pkg::REG_GAIN, phase_gain[ph]);
         write_csr(dofa_pkg::REG_DELAY, phase_delay[ph]);
         csr_valid <= 1'b0;
         calm = (ph == NUM_PHASES - 1);
         start = ticks_sent;
         while (ticks_sent - start < PHASE_TICKS) begin
            kind = $urandom_range(0, 99);
            if (kind < 45) begin
               // gait-like swing: legs half a period apart
               amp    = $urandom_range(0, ANGLE_MAX);
               period = $urandom_range(8, 48);
               offs   = $urandom_range(0, 47);
               len    = $urandom_range(10, 40);
               for (k = 0; k < len; k++)
                  send_tick(clamp_angle(tri_wave(k + offs, period, amp) +
                                        int'($urandom_range(0, 400)) - 200),
                            clamp_angle(tri_wave(k + offs + period / 2, period, amp) +
                                        int'($urandom_range(0, 400)) - 200));
            end else if (kind < 65) begin
               len = $urandom_range(1, 10);
               for (k = 0; k < len; k++) begin
                  if ($urandom_range(0, 19) == 0)
                     send_tick($urandom, $urandom);
                  else
                     send_tick(int'($urandom_range(0, 2 * ANGLE_MAX)) - ANGLE_MAX,
                               int'($urandom_range(0, 2 * ANGLE_MAX)) - ANGLE_MAX);
               end
            end else begin
               if (kind < 85) begin
                  // pull both filters to zero so the next tick reloads
                  guard = 0;
                  while ((board.filt_l != 0 || board.filt_r != 0) && guard < 60) begin
                     send_tick(zero_pull(board.filt_l), zero_pull(board.filt_r));
                     guard++;
                  end
               end
               len = $urandom_range(1, 4);
               for (k = 0; k < len; k++)
                  send_tick(extreme_angle($urandom_range(0, 6)),
                            extreme_angle($urandom_range(0, 6)));
            end
         end
         req_tvalid <= 1'b0;
      end

      while (board.pending() != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      $display("covered %0d ticks over %0d register settings, %0d filter reloads",
               ticks_sent, NUM_PHASES + 1, board.reloads);
      $display("compared %0d torque transfers, %0d mismatches", board.checked, board.mismatches);
      if (board.mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

/* files.f */
src/dofa_pkg.sv
src/dofa_sine.sv
src/dofa_ctrl.sv
src/dofa_dp.sv
src/delayed_output_feedback_assist_core.sv
bench/tb.sv
